@@ design/tdbg_pkg.sv @@
// Shared types and constants for the torus double-banked grid store.
// Holds the command enum, status and mode codes and the decoded operation word.
// No dependencies.
package tdbg_pkg;

   // Grid geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Field widths
   localparam int DIM_W      = 7;
   localparam int COORD_W    = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ADD   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

   // Bank modes
   localparam logic [MODE_W-1:0] MODE_A_TO_B = 2'd0;
   localparam logic [MODE_W-1:0] MODE_B_TO_A = 2'd1;
   localparam logic [MODE_W-1:0] MODE_B_ONLY = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BANK_MODE   = 2'd2;

   // Decoded operation, held for the read and execute cycles
   typedef struct packed {
      cmd_type                    cmd;
      logic [ADDR_W-1:0]          addr;
      logic                       fault;     // coordinate out of reach
      logic                       rd_from_b; // read command sources bank B
      logic                       rd_none;   // read command sources nothing
      logic                       wr_none;   // write and add are dropped
      logic                       wr_to_a;   // write and add target bank A
      logic signed [VALUE_W-1:0]  value;
   } op_type;

endpackage

@@ design/tdbg_bank.sv @@
// One grid bank: a single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on tdbg_pkg.
module tdbg_bank (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [tdbg_pkg::ADDR_W-1:0]       wr_addr,
   input  logic [tdbg_pkg::VALUE_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [tdbg_pkg::ADDR_W-1:0]       rd_addr,
   output logic [tdbg_pkg::VALUE_W-1:0]      rd_data_ff
);

   logic [tdbg_pkg::VALUE_W-1:0] mem [tdbg_pkg::CELLS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ design/tdbg_addr_gen.sv @@
// Decode stage: clamps the grid size, wraps read coordinates like a torus and forms
// the cell address y * width + x. Registers the decoded word. Depends on tdbg_pkg.
module tdbg_addr_gen (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic [1:0]                            command,
   input  logic signed [tdbg_pkg::COORD_W-1:0]   x_coord,
   input  logic signed [tdbg_pkg::COORD_W-1:0]   y_coord,
   input  logic signed [tdbg_pkg::VALUE_W-1:0]   write_value,
   input  logic [tdbg_pkg::DIM_W-1:0]            grid_width,
   input  logic [tdbg_pkg::DIM_W-1:0]            grid_height,
   input  logic [tdbg_pkg::MODE_W-1:0]           bank_mode,
   output tdbg_pkg::op_type                      op_ff
);

   localparam int EXT_W  = tdbg_pkg::DIM_W + 3;
   localparam int PROD_W = tdbg_pkg::ROW_W + tdbg_pkg::DIM_W;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [tdbg_pkg::DIM_W-1:0] eff_dim(
      input logic [tdbg_pkg::DIM_W-1:0] v,
      input logic [tdbg_pkg::DIM_W-1:0] max_v
   );
      logic [tdbg_pkg::DIM_W-1:0] r;
      if (v == '0) r = tdbg_pkg::DIM_W'(1);
      else if (v > max_v) r = max_v;
      else r = v;
      return r;
   endfunction

   // wraps c once into [0, n); top bit set when c lies within one wrap
   function automatic logic [tdbg_pkg::DIM_W:0] wrap_once(
      input logic signed [tdbg_pkg::COORD_W-1:0] c,
      input logic [tdbg_pkg::DIM_W-1:0]          n
   );
      logic signed [EXT_W-1:0] cs;
      logic signed [EXT_W-1:0] ns;
      logic signed [EXT_W-1:0] r;
      logic                    ok;
      cs = {{(EXT_W-tdbg_pkg::COORD_W){c[tdbg_pkg::COORD_W-1]}}, c};
      ns = {{(EXT_W-tdbg_pkg::DIM_W){1'b0}}, n};
      ok = (cs >= -ns) && (cs < (ns <<< 1));
      if (cs < 0) r = cs + ns;
      else if (cs >= ns) r = cs - ns;
      else r = cs;
      return {ok, r[tdbg_pkg::DIM_W-1:0]};
   endfunction

   // true when 0 <= c < n
   function automatic logic in_grid(
      input logic signed [tdbg_pkg::COORD_W-1:0] c,
      input logic [tdbg_pkg::DIM_W-1:0]          n
   );
      logic signed [EXT_W-1:0] cs;
      logic signed [EXT_W-1:0] ns;
      cs = {{(EXT_W-tdbg_pkg::COORD_W){c[tdbg_pkg::COORD_W-1]}}, c};
      ns = {{(EXT_W-tdbg_pkg::DIM_W){1'b0}}, n};
      return (cs >= 0) && (cs < ns);
   endfunction

   logic [tdbg_pkg::DIM_W-1:0] w;
   logic [tdbg_pkg::DIM_W-1:0] h;
   logic [tdbg_pkg::DIM_W:0]   wx;
   logic [tdbg_pkg::DIM_W:0]   wy;
   logic [tdbg_pkg::COL_W-1:0] cx;
   logic [tdbg_pkg::ROW_W-1:0] cy;
   logic [PROD_W-1:0]          cell_sum;
   logic                       rd_fault;
   logic                       wr_fault;
   tdbg_pkg::cmd_type          cmd;
   tdbg_pkg::op_type           op_in;

   // geometry and wrap
   always_comb begin
      w        = eff_dim(grid_width, tdbg_pkg::DIM_W'(tdbg_pkg::MAX_WIDTH));
      h        = eff_dim(grid_height, tdbg_pkg::DIM_W'(tdbg_pkg::MAX_HEIGHT));
      wx       = wrap_once(x_coord, w);
      wy       = wrap_once(y_coord, h);
      cx       = wx[tdbg_pkg::COL_W-1:0];
      cy       = wy[tdbg_pkg::ROW_W-1:0];
      cell_sum = PROD_W'(cy) * PROD_W'(w) + PROD_W'(cx);
      rd_fault = !(wx[tdbg_pkg::DIM_W] && wy[tdbg_pkg::DIM_W]);
      wr_fault = !(in_grid(x_coord, w) && in_grid(y_coord, h));
      cmd      = tdbg_pkg::cmd_type'(command);
   end

   // decoded word
   always_comb begin
      op_in.cmd       = cmd;
      op_in.addr      = cell_sum[tdbg_pkg::ADDR_W-1:0];
      op_in.fault     = (cmd == tdbg_pkg::CMD_READ) ? rd_fault : wr_fault;
      op_in.rd_from_b = (bank_mode == tdbg_pkg::MODE_B_TO_A) ||
                        (bank_mode == tdbg_pkg::MODE_B_ONLY);
      op_in.rd_none   = !(op_in.rd_from_b || (bank_mode == tdbg_pkg::MODE_A_TO_B));
      op_in.wr_to_a   = (bank_mode == tdbg_pkg::MODE_B_TO_A);
      op_in.wr_none   = !(op_in.wr_to_a || (bank_mode == tdbg_pkg::MODE_A_TO_B) ||
                          (bank_mode == tdbg_pkg::MODE_B_ONLY));
      op_in.value     = write_value;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= op_in;
      end
   end

endmodule

@@ design/torus_double_buffered_grid_store.sv @@
// Torus double-banked grid store: read, write, saturating add and clear on two banks.
// A read, write or add word strobes on rsp_ after the decode register, memory read, execute
// and registered result; a new word can be taken while the last one executes, but not during
// its memory read (busy high), as the read-modify-write goes through the single bank read port.
// Clear and synchronous reset sweep all 4096 entries of both banks one entry a cycle, busy high,
// then one strobe after a clear, none after reset. Depends on tdbg_pkg, tdbg_addr_gen, tdbg_bank.
module torus_double_buffered_grid_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_command,
   input  logic signed [tdbg_pkg::COORD_W-1:0]   req_x_coord,
   input  logic signed [tdbg_pkg::COORD_W-1:0]   req_y_coord,
   input  logic signed [tdbg_pkg::VALUE_W-1:0]   req_write_value,
   output logic                                  rsp_strobe,
   output logic signed [tdbg_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [tdbg_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  csr_write_enable,
   input  logic [tdbg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tdbg_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_CLEAR
   } state_type;

   localparam int SUM_W = tdbg_pkg::VALUE_W + 1;

   state_type                          state_ff;
   logic [tdbg_pkg::ADDR_W-1:0]        clr_idx_ff;
   logic                               clr_rsp_ff;
   logic                               rsp_strobe_ff;
   logic signed [tdbg_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [tdbg_pkg::STATUS_W-1:0]      rsp_status_ff;

   logic [tdbg_pkg::DIM_W-1:0]         grid_width_ff;
   logic [tdbg_pkg::DIM_W-1:0]         grid_height_ff;
   logic [tdbg_pkg::MODE_W-1:0]        bank_mode_ff;

   tdbg_pkg::op_type                   op_ff;
   logic                               accept;
   logic                               clear_cmd;

   logic [tdbg_pkg::VALUE_W-1:0]       a_q;
   logic [tdbg_pkg::VALUE_W-1:0]       b_q;
   logic                               wr_a;
   logic                               wr_b;
   logic [tdbg_pkg::ADDR_W-1:0]        wr_addr;
   logic [tdbg_pkg::VALUE_W-1:0]       wr_data;
   logic                               rd_en;

   logic signed [tdbg_pkg::VALUE_W-1:0] target_q;
   logic signed [SUM_W-1:0]            sum;
   logic                               sat;
   logic signed [tdbg_pkg::VALUE_W-1:0] sum_clip;
   logic                               exec_write;
   logic signed [tdbg_pkg::VALUE_W-1:0] exec_wdata;
   logic signed [tdbg_pkg::VALUE_W-1:0] exec_value;
   logic [tdbg_pkg::STATUS_W-1:0]      exec_status;

   // handshake
   assign busy      = (state_ff == ST_READ) || (state_ff == ST_CLEAR);
   assign accept    = start && !busy;
   assign clear_cmd = (tdbg_pkg::cmd_type'(req_command) == tdbg_pkg::CMD_CLEAR);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= tdbg_pkg::DIM_W'(64);
         grid_height_ff <= tdbg_pkg::DIM_W'(64);
         bank_mode_ff   <= tdbg_pkg::MODE_B_ONLY;
      end else if (csr_write_enable) begin
         case (csr_index)
            tdbg_pkg::REG_GRID_WIDTH: begin
               grid_width_ff <= csr_write_data;
            end
            tdbg_pkg::REG_GRID_HEIGHT: begin
               grid_height_ff <= csr_write_data;
            end
            tdbg_pkg::REG_BANK_MODE: begin
               bank_mode_ff <= csr_write_data[tdbg_pkg::MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // decode stage
   tdbg_addr_gen u_addr_gen (
      .clock       (clock),
      .load        (accept),
      .command     (req_command),
      .x_coord     (req_x_coord),
      .y_coord     (req_y_coord),
      .write_value (req_write_value),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .bank_mode   (bank_mode_ff),
      .op_ff       (op_ff)
   );

   // execute: select data, saturating add, result word
   always_comb begin
      target_q    = op_ff.wr_to_a ? a_q : b_q;
      sum         = {target_q[tdbg_pkg::VALUE_W-1], target_q} +
                    {op_ff.value[tdbg_pkg::VALUE_W-1], op_ff.value};
      sat         = sum[SUM_W-1] != sum[SUM_W-2];
      sum_clip    = sum[SUM_W-1] ? {1'b1, {(tdbg_pkg::VALUE_W-1){1'b0}}}
                                 : {1'b0, {(tdbg_pkg::VALUE_W-1){1'b1}}};
      if (!sat) sum_clip = sum[tdbg_pkg::VALUE_W-1:0];
      exec_write  = 1'b0;
      exec_wdata  = op_ff.value;
      exec_value  = '0;
      exec_status = tdbg_pkg::STATUS_OK;
      case (op_ff.cmd)
         tdbg_pkg::CMD_READ: begin
            if (op_ff.fault) begin
               exec_status = tdbg_pkg::STATUS_RANGE;
            end else if (!op_ff.rd_none) begin
               exec_value = op_ff.rd_from_b ? b_q : a_q;
            end
         end
         tdbg_pkg::CMD_WRITE: begin
            if (op_ff.fault) begin
               exec_status = tdbg_pkg::STATUS_RANGE;
            end else begin
               exec_write = !op_ff.wr_none;
            end
         end
         tdbg_pkg::CMD_ADD: begin
            if (op_ff.fault) begin
               exec_status = tdbg_pkg::STATUS_RANGE;
            end else if (!op_ff.wr_none) begin
               exec_write = 1'b1;
               exec_wdata = sum_clip;
               if (sat) exec_status = tdbg_pkg::STATUS_SAT;
            end
         end
         default: begin
         end
      endcase
   end

   // memory ports: sweep during clear, write-back during execute
   always_comb begin
      rd_en = (state_ff == ST_READ);
      if (state_ff == ST_CLEAR) begin
         wr_a    = 1'b1;
         wr_b    = 1'b1;
         wr_addr = clr_idx_ff;
         wr_data = '0;
      end else begin
         wr_a    = (state_ff == ST_EXEC) && exec_write && op_ff.wr_to_a;
         wr_b    = (state_ff == ST_EXEC) && exec_write && !op_ff.wr_to_a;
         wr_addr = op_ff.addr;
         wr_data = exec_wdata;
      end
   end

   tdbg_bank u_bank_a (
      .clock      (clock),
      .wr_en      (wr_a),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (op_ff.addr),
      .rd_data_ff (a_q)
   );

   tdbg_bank u_bank_b (
      .clock      (clock),
      .wr_en      (wr_b),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (op_ff.addr),
      .rd_data_ff (b_q)
   );

   // sequencer and registered result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE, ST_EXEC: begin
               if (state_ff == ST_EXEC) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_value_ff  <= exec_value;
                  rsp_status_ff <= exec_status;
               end
               if (accept) begin
                  if (clear_cmd) begin
                     state_ff   <= ST_CLEAR;
                     clr_idx_ff <= '0;
                     clr_rsp_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == tdbg_pkg::ADDR_W'(tdbg_pkg::CELLS - 1)) begin
                  state_ff      <= ST_IDLE;
                  clr_rsp_ff    <= 1'b0;
                  rsp_strobe_ff <= clr_rsp_ff;
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= tdbg_pkg::STATUS_OK;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   // checks
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      (accept && !clear_cmd) |=> (state_ff == ST_READ))
      else $error("accepted word did not start a memory read");

   a_read_to_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_EXEC) && rsp_strobe == 1'b0)
      else $error("memory read not followed by execute");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && op_ff.fault) |-> !(wr_a || wr_b))
      else $error("out-of-reach word wrote a bank");

   a_dual_write_clear: assert property (@(posedge clock) disable iff (reset)
      (wr_a && wr_b) |-> (state_ff == ST_CLEAR))
      else $error("both banks written outside the clearing sweep");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == tdbg_pkg::STATUS_RANGE) |-> (rsp_read_value == '0))
      else $error("range error word carries a non-zero value");

endmodule
